>>> rtl/hes_pkg.sv
// shared types and constants for the hashed entry store
package hes_pkg;

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NOTFOUND = 1'b1;

  localparam int KEY_W   = 64;
  localparam int PAY_W   = 192;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;
  localparam int COUNT_W = 7;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] dim_m;
    logic [31:0] dim_n;
    logic [31:0] dim_k;
    logic [15:0] thread_count;
    logic [15:0] tile_width;
    logic [31:0] operation_kind;
    logic [31:0] kernel_id;
    logic [63:0] perf_bits;
    logic [63:0] bench_bits;
    logic [31:0] insert_time;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] found_kernel;
    logic [63:0] found_perf;
    logic [63:0] found_bench;
    logic [31:0] found_time;
    logic [6:0]  entry_count;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] evict_count;
  } rsp_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

endpackage

>>> rtl/hes_req_if.sv
// request channel interface
interface hes_req_if;
  logic            valid;
  logic            ready;
  hes_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/hes_rsp_if.sv
// result channel interface
interface hes_rsp_if;
  logic            valid;
  logic            ready;
  hes_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/hes_ram.sv
// generic single port ram with registered read
module hes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/hashed_entry_store_oldest_evict_core.sv
// keyed result store with fnv-1a key folding and oldest-timestamp eviction
// One request at a time. Key folding takes the six fields in turn, each
// through one shared unit in a low pass and a high pass (the low pass
// multiplies the xored key by the low half of the prime, and the high half
// of the prime is 0x100, so the second pass adds a shifted term). Then a
// scan over the slot memory finds the matching key, the first free slot and
// the oldest valid slot in the same pass; it ends with the registered memory
// read of the last slot and the decision. An insert of a new key into a full
// table adds S_EVICT; a query hit adds S_READ and S_READ2 to read the payload
// memory. An insert that needs no eviction writes at the decision, and every
// request answers from S_DONE; a clear goes straight there from idle.
// Slot valid bits live in flip-flops and reset or clear at once; key, time
// and payload live in single-port memories. Input is ready whenever the
// sequencer is idle; the result waits in its own register, so the next
// request is taken and worked on while the previous result is still unread,
// and S_DONE holds only until that result has been taken.
module hashed_entry_store_oldest_evict_core #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  hes_req_if.sink     req,
  hes_rsp_if.source   rsp
);
  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int SW = AW + 1;  // scan counter that reaches TABLE_SLOTS+1
  localparam int VW = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_SCAN, S_EVICT, S_READ, S_READ2, S_DONE
  } state_t;

  state_t state;
  hes_pkg::req_t r;
  logic [6:0]  entry_limit;
  logic [63:0] key;
  logic [2:0]  fld;
  logic        half;
  logic [63:0] lo_prod;  // low partial product of the current fold
  logic [SW-1:0] scan;
  logic        rd_live;   // memory read data refers to slot scan-1
  logic [AW-1:0] rd_slot;
  logic        hit, have_free, have_old;
  logic [AW-1:0] hit_slot, free_slot, old_slot;
  logic [31:0] old_time;
  logic [TABLE_SLOTS-1:0] valid;
  logic [VW-1:0] valid_total;
  logic [31:0] hits_total, misses_total, evictions_total;

  // memories
  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [95:0]     kt_wdata, kt_rdata;  // key and time
  logic [159:0]    pl_wdata, pl_rdata;  // kernel, perf, bench

  hes_ram #(.WIDTH(96), .DEPTH(TABLE_SLOTS)) u_kt_ram (
    .clk, .we(mem_we), .addr(mem_addr), .wdata(kt_wdata), .rdata(kt_rdata)
  );
  hes_ram #(.WIDTH(160), .DEPTH(TABLE_SLOTS)) u_pl_ram (
    .clk, .we(mem_we), .addr(mem_addr), .wdata(pl_wdata), .rdata(pl_rdata)
  );

  // current field of the signature, zero extended
  logic [63:0] fld_val;
  always_comb begin
    case (fld)
      3'd0: fld_val = {32'd0, r.dim_m};
      3'd1: fld_val = {32'd0, r.dim_n};
      3'd2: fld_val = {32'd0, r.dim_k};
      3'd3: fld_val = {48'd0, r.thread_count};
      3'd4: fld_val = {48'd0, r.tile_width};
      default: fld_val = {32'd0, r.operation_kind};
    endcase
  end

  // shared multiplier: 64x32 of the xored key by one half of the prime.
  // prime high half is 0x100, so the high pass is a shift, the low pass a mult
  logic [63:0] kx;
  logic [63:0] mul_out;
  assign kx = key ^ fld_val;
  assign mul_out = kx * {32'd0, hes_pkg::FNV_PRIME[31:0]};

  // effective limit
  logic [VW:0] limit;
  always_comb begin
    if (entry_limit == 7'd0 || {{(VW+1){1'b0}}, entry_limit} > (VW+8)'(TABLE_SLOTS))
      limit = (VW+1)'(TABLE_SLOTS);
    else
      limit = (VW+1)'(entry_limit);
  end

  // memory slot seen in this scan cycle
  logic        cur_valid;
  logic [31:0] cur_time;
  assign cur_valid = rd_live && valid[rd_slot];
  assign cur_time  = kt_rdata[31:0];

  // after eviction the lowest free slot is min(old_slot, free_slot)
  logic [AW-1:0] have_free_after_evict;
  always_comb begin
    if (!have_free || old_slot < free_slot)
      have_free_after_evict = old_slot;
    else
      have_free_after_evict = free_slot;
  end

  // valid bits once the oldest entry leaves and the new one lands
  logic [TABLE_SLOTS-1:0] valid_evict_next;
  always_comb begin
    valid_evict_next = valid;
    valid_evict_next[old_slot] = 1'b0;
    valid_evict_next[have_free_after_evict] = 1'b1;
  end

  // result register loads once the previous result has gone
  logic out_load;
  assign out_load = (state == S_DONE) && (!rsp.valid || rsp.ready);

  logic [AW-1:0] ins_slot;

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = scan[AW-1:0];
    kt_wdata = {key, r.insert_time};
    pl_wdata = {r.kernel_id, r.perf_bits, r.bench_bits};
    ins_slot = hit ? hit_slot : free_slot;
    case (state)
      S_SCAN: begin
        mem_addr = scan[AW-1:0];
      end
      S_EVICT: begin
        mem_addr = old_slot;
      end
      S_READ, S_READ2: begin
        mem_addr = hit_slot;
      end
      S_DONE: begin
        mem_addr = ins_slot;
      end
      default: begin
        mem_addr = scan[AW-1:0];
      end
    endcase
    // the write happens at the scan decision, see the sequencer
    if (state == S_SCAN && scan == SW'(TABLE_SLOTS + 1) &&
        r.command == hes_pkg::CMD_INSERT &&
        (hit || ({1'b0, valid_total} < limit))) begin
      mem_we = 1'b1;
      mem_addr = hit ? hit_slot : free_slot;
    end else if (state == S_EVICT) begin
      mem_we = 1'b1;  // land in the lowest free slot: the evicted one or a lower free one
      mem_addr = have_free_after_evict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      entry_limit     <= 7'd0;
      valid           <= '0;
      valid_total     <= '0;
      hits_total      <= '0;
      misses_total    <= '0;
      evictions_total <= '0;
      rsp.valid       <= 1'b0;
      rd_live         <= 1'b0;
    end else begin
      if (cfg_we) begin
        entry_limit <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            r     <= req.payload;
            key   <= hes_pkg::FNV_BASIS;
            fld   <= 3'd0;
            half  <= 1'b0;
            state <= (req.payload.command == hes_pkg::CMD_CLEAR) ? S_DONE : S_HASH;
          end
        end
        S_HASH: begin
          // each field: low product first, then add the shifted term
          if (!half) begin
            lo_prod <= mul_out;
            half    <= 1'b1;
          end else begin
            key  <= lo_prod + {kx[23:0], 40'd0};
            half <= 1'b0;
            fld  <= fld + 3'd1;
            if (fld == 3'd5) begin
              state     <= S_SCAN;
              scan      <= '0;
              rd_live   <= 1'b0;
              hit       <= 1'b0;
              have_free <= 1'b0;
              have_old  <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          rd_slot <= scan[AW-1:0];
          rd_live <= (scan < SW'(TABLE_SLOTS));
          if (rd_live) begin
            if (cur_valid && !hit && kt_rdata[95:32] == key) begin
              hit      <= 1'b1;
              hit_slot <= rd_slot;
            end
            if (!valid[rd_slot] && !have_free) begin
              have_free <= 1'b1;
              free_slot <= rd_slot;
            end
            if (cur_valid && (!have_old || cur_time < old_time)) begin
              have_old <= 1'b1;
              old_slot <= rd_slot;
              old_time <= cur_time;
            end
          end
          if (scan != SW'(TABLE_SLOTS + 1)) begin
            scan <= scan + SW'(1);
          end else begin
            // last slot has been folded in, decide
            case (r.command)
              hes_pkg::CMD_QUERY: begin
                if (hit) begin
                  hits_total <= hes_pkg::sat_inc(hits_total);
                  state <= S_READ;
                end else begin
                  misses_total <= hes_pkg::sat_inc(misses_total);
                  state <= S_DONE;
                end
              end
              hes_pkg::CMD_INSERT: begin
                if (!hit && {1'b0, valid_total} >= limit) begin
                  state <= S_EVICT;
                end else begin
                  state <= S_DONE;
                  if (!hit) begin
                    valid[free_slot] <= 1'b1;
                    valid_total      <= valid_total + VW'(1);
                  end
                end
              end
              hes_pkg::CMD_REMOVE: begin
                state <= S_DONE;
                if (hit) begin
                  valid[hit_slot] <= 1'b0;
                  valid_total     <= valid_total - VW'(1);
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_EVICT: begin
          // old entry leaves, new entry lands in the lowest free slot
          evictions_total <= hes_pkg::sat_inc(evictions_total);
          valid <= valid_evict_next;
          state <= S_DONE;
        end
        S_READ: begin
          state <= S_READ2;
        end
        S_READ2: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            if ((r.command == hes_pkg::CMD_QUERY || r.command == hes_pkg::CMD_REMOVE)
                && !hit) begin
              rsp.payload.status <= hes_pkg::STATUS_NOTFOUND;
            end else begin
              rsp.payload.status <= hes_pkg::STATUS_OK;
            end
            if (r.command == hes_pkg::CMD_QUERY && hit) begin
              rsp.payload.found_kernel <= pl_rdata[159:128];
              rsp.payload.found_perf   <= pl_rdata[127:64];
              rsp.payload.found_bench  <= pl_rdata[63:0];
              rsp.payload.found_time   <= kt_rdata[31:0];
            end else begin
              rsp.payload.found_kernel <= 32'd0;
              rsp.payload.found_perf   <= 64'd0;
              rsp.payload.found_bench  <= 64'd0;
              rsp.payload.found_time   <= 32'd0;
            end
            if (r.command == hes_pkg::CMD_CLEAR) begin
              valid       <= '0;
              valid_total <= '0;
              rsp.payload.entry_count <= 7'd0;
            end else begin
              rsp.payload.entry_count <= 7'(valid_total);
            end
            rsp.payload.hit_count   <= hits_total;
            rsp.payload.miss_count  <= misses_total;
            rsp.payload.evict_count <= evictions_total;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  assign req.ready = (state == S_IDLE);

endmodule

>>> rtl/hes_checker.sv
// port-level checks for the hashed entry store
module hes_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input hes_pkg::rsp_t rsp_payload
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("result dropped or changed while stalled");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_payload.entry_count <= 7'd64)
    else $error("entry count out of range");
  a_hit_mono: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) && $past(rsp_valid, 2) |->
      rsp_payload.hit_count >= $past(rsp_payload.hit_count, 2))
    else $error("hit counter went backward");
endmodule

bind hashed_entry_store_oldest_evict_core hes_checker u_hes_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

>>> sim/hes_tb_if.sv
// constants shared by the testbench
package hes_tb_consts;
  localparam int LONG_HOLD = 400;
endpackage

>>> sim/testbench.sv
// self-checking testbench for the hashed entry store with oldest-timestamp eviction
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  hes_req_if req_ch ();
  hes_rsp_if rsp_ch ();

  hashed_entry_store_oldest_evict_core #(.TABLE_SLOTS(SLOTS)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always #2 clk = ~clk;

  // predictor state, mirrors the table contents
  logic        tbl_valid [SLOTS];
  logic [63:0] tbl_key [SLOTS];
  logic [31:0] tbl_kernel [SLOTS];
  logic [63:0] tbl_perf [SLOTS];
  logic [63:0] tbl_bench [SLOTS];
  logic [31:0] tbl_time [SLOTS];
  int unsigned live_entries;
  logic [31:0] hits_seen, misses_seen, evictions_seen;
  logic [6:0]  limit_reg;

  hes_pkg::req_t pending_reqs[$];
  hes_pkg::rsp_t expected_rsps[$];
  int   mismatches;
  int   send_idle_pct, recv_stall_pct;
  bit   hold_recv;
  int   hold_cycles;
  bit   req_taken;

  function automatic logic [63:0] fnv_key(hes_pkg::req_t r);
    logic [63:0] h;
    h = hes_pkg::FNV_BASIS;
    h = (h ^ {32'd0, r.dim_m}) * hes_pkg::FNV_PRIME;
    h = (h ^ {32'd0, r.dim_n}) * hes_pkg::FNV_PRIME;
    h = (h ^ {32'd0, r.dim_k}) * hes_pkg::FNV_PRIME;
    h = (h ^ {48'd0, r.thread_count}) * hes_pkg::FNV_PRIME;
    h = (h ^ {48'd0, r.tile_width}) * hes_pkg::FNV_PRIME;
    h = (h ^ {32'd0, r.operation_kind}) * hes_pkg::FNV_PRIME;
    return h;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  // apply one request to the table model and return the expected answer
  function automatic hes_pkg::rsp_t store_predict(hes_pkg::req_t r);
    hes_pkg::rsp_t o;
    logic [63:0] k;
    int hit, free_slot, old_slot, lim;
    o = '0;
    k = fnv_key(r);
    hit = -1;
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && tbl_valid[i] && tbl_key[i] == k) hit = i;
    lim = (limit_reg == 0 || limit_reg > SLOTS) ? SLOTS : limit_reg;
    o.status = hes_pkg::STATUS_OK;
    case (hes_pkg::cmd_t'(r.command))
      hes_pkg::CMD_QUERY: begin
        if (hit < 0) begin
          o.status = hes_pkg::STATUS_NOTFOUND;
          misses_seen = bump(misses_seen);
        end else begin
          o.found_kernel = tbl_kernel[hit];
          o.found_perf = tbl_perf[hit];
          o.found_bench = tbl_bench[hit];
          o.found_time = tbl_time[hit];
          hits_seen = bump(hits_seen);
        end
      end
      hes_pkg::CMD_INSERT: begin
        if (hit < 0) begin
          if (live_entries >= lim) begin
            old_slot = -1;
            for (int i = 0; i < SLOTS; i++)
              if (tbl_valid[i] && (old_slot < 0 || tbl_time[i] < tbl_time[old_slot]))
                old_slot = i;
            if (old_slot >= 0) begin
              tbl_valid[old_slot] = 1'b0;
              live_entries--;
              evictions_seen = bump(evictions_seen);
            end
          end
          free_slot = -1;
          for (int i = 0; i < SLOTS; i++)
            if (free_slot < 0 && !tbl_valid[i]) free_slot = i;
          if (free_slot >= 0) begin
            tbl_valid[free_slot] = 1'b1;
            live_entries++;
          end
          hit = free_slot;
        end
        if (hit >= 0) begin
          tbl_key[hit] = k;
          tbl_kernel[hit] = r.kernel_id;
          tbl_perf[hit] = r.perf_bits;
          tbl_bench[hit] = r.bench_bits;
          tbl_time[hit] = r.insert_time;
        end
      end
      hes_pkg::CMD_REMOVE: begin
        if (hit < 0) o.status = hes_pkg::STATUS_NOTFOUND;
        else begin
          tbl_valid[hit] = 1'b0;
          live_entries--;
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        live_entries = 0;
      end
    endcase
    o.entry_count = live_entries[6:0];
    o.hit_count = hits_seen;
    o.miss_count = misses_seen;
    o.evict_count = evictions_seen;
    return o;
  endfunction

  // small pool of signatures so that keys repeat often
  hes_pkg::req_t sig_pool[16];

  function automatic hes_pkg::req_t rand_fields();
    hes_pkg::req_t r;
    r.command = 2'($urandom_range(0, 3));
    r.dim_m = $urandom; r.dim_n = $urandom; r.dim_k = $urandom;
    r.thread_count = 16'($urandom); r.tile_width = 16'($urandom);
    r.operation_kind = $urandom; r.kernel_id = $urandom;
    r.perf_bits = {$urandom, $urandom}; r.bench_bits = {$urandom, $urandom};
    r.insert_time = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
    return r;
  endfunction

  function automatic hes_pkg::req_t pool_req(int pool_n);
    hes_pkg::req_t r, s;
    int pick;
    r = rand_fields();
    s = sig_pool[$urandom_range(0, pool_n - 1)];
    r.dim_m = s.dim_m; r.dim_n = s.dim_n; r.dim_k = s.dim_k;
    r.thread_count = s.thread_count; r.tile_width = s.tile_width;
    r.operation_kind = s.operation_kind;
    pick = $urandom_range(0, 99);
    // mostly queries and inserts, clear is rare
    r.command = pick < 40 ? hes_pkg::CMD_QUERY : pick < 80 ? hes_pkg::CMD_INSERT :
                pick < 97 ? hes_pkg::CMD_REMOVE : hes_pkg::CMD_CLEAR;
    return r;
  endfunction

  // driver: offers queued requests, idling at random, changes at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      // previous request taken (or none offered): choose what comes next
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_ch.payload <= pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // acceptance is taken at the rising edge; prediction runs here
  always @(posedge clk) begin
    req_taken <= !rst && req_ch.valid && req_ch.ready;
    if (!rst && req_ch.valid && req_ch.ready)
      expected_rsps.push_back(store_predict(req_ch.payload));
  end

  // receiver stall pattern, with a long hold-off counted separately
  always @(negedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else if (hold_recv) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    hold_recv <= (hold_cycles > 1);
  end

  // monitor: compare each taken result with the oldest expectation
  always @(posedge clk) begin
    hes_pkg::rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", rsp_ch.payload);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_ch.payload !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp st=%0d k=%h p=%h b=%h t=%h n=%0d h=%0d m=%0d e=%0d",
              want.status, want.found_kernel, want.found_perf, want.found_bench,
              want.found_time, want.entry_count, want.hit_count, want.miss_count,
              want.evict_count);
            $display("          got st=%0d k=%h p=%h b=%h t=%h n=%0d h=%0d m=%0d e=%0d",
              rsp_ch.payload.status, rsp_ch.payload.found_kernel,
              rsp_ch.payload.found_perf, rsp_ch.payload.found_bench,
              rsp_ch.payload.found_time, rsp_ch.payload.entry_count,
              rsp_ch.payload.hit_count, rsp_ch.payload.miss_count,
              rsp_ch.payload.evict_count);
          end
        end
      end
    end
  end

  // wait until driver queue empty and every result back
  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_limit(logic [6:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    limit_reg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // directed item with a chosen signature
  task automatic push_sig(hes_pkg::cmd_t c, hes_pkg::req_t s, logic [31:0] t);
    hes_pkg::req_t r;
    r = rand_fields();
    r.dim_m = s.dim_m; r.dim_n = s.dim_n; r.dim_k = s.dim_k;
    r.thread_count = s.thread_count; r.tile_width = s.tile_width;
    r.operation_kind = s.operation_kind;
    r.command = c;
    r.insert_time = t;
    pending_reqs.push_back(r);
  endtask

  initial begin
    hes_pkg::req_t zero_sig, ones_sig, tie_sig;
    int limits[6];
    int pool_n;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
    hold_recv = 1'b0;
    hold_cycles = 0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    live_entries = 0;
    hits_seen = '0; misses_seen = '0; evictions_seen = '0;
    limit_reg = '0;
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < 16; i++) sig_pool[i] = rand_fields();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part: extremes of the signature, each command, an eviction
    set_limit(7'd2);
    zero_sig = '0;
    ones_sig = '1;
    tie_sig = rand_fields();
    push_sig(hes_pkg::CMD_QUERY, zero_sig, 0);
    push_sig(hes_pkg::CMD_REMOVE, zero_sig, 0);
    push_sig(hes_pkg::CMD_INSERT, zero_sig, 32'd5);
    push_sig(hes_pkg::CMD_INSERT, ones_sig, 32'd5);
    push_sig(hes_pkg::CMD_QUERY, ones_sig, 0);
    push_sig(hes_pkg::CMD_INSERT, ones_sig, 32'hFFFF_FFFF);
    push_sig(hes_pkg::CMD_INSERT, tie_sig, 32'd0);
    push_sig(hes_pkg::CMD_QUERY, zero_sig, 0);
    push_sig(hes_pkg::CMD_QUERY, ones_sig, 0);
    push_sig(hes_pkg::CMD_QUERY, tie_sig, 0);
    push_sig(hes_pkg::CMD_REMOVE, tie_sig, 0);
    push_sig(hes_pkg::CMD_REMOVE, tie_sig, 0);
    push_sig(hes_pkg::CMD_CLEAR, ones_sig, 0);
    push_sig(hes_pkg::CMD_QUERY, ones_sig, 0);
    drain();
    // limit above capacity and then lowered below the current count
    set_limit(7'd127);
    for (int i = 0; i < 5; i++) push_sig(hes_pkg::CMD_INSERT, sig_pool[i], 32'd3);
    drain();
    set_limit(7'd1);
    push_sig(hes_pkg::CMD_INSERT, sig_pool[8], 32'd9);
    push_sig(hes_pkg::CMD_QUERY, sig_pool[0], 0);
    push_sig(hes_pkg::CMD_INSERT, sig_pool[0], 32'd1);
    drain();

    // random phases across limits and idle mixes
    limits = '{0, 1, 64, 3, 100, 8};
    for (int ph = 0; ph < 6; ph++) begin
      set_limit(7'(limits[ph]));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      pool_n = (ph == 2) ? 16 : 12;
      for (int i = 0; i < 240; i++) begin
        if ($urandom_range(0, 9) == 0) pending_reqs.push_back(rand_fields());
        else pending_reqs.push_back(pool_req(pool_n));
      end
      if (ph == 1) begin
        // receiver holds off while the sender keeps offering
        wait (pending_reqs.size() < 200);
        hold_cycles = hes_tb_consts::LONG_HOLD;
      end
      drain();
    end

    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/hes_pkg.sv
rtl/hes_req_if.sv
rtl/hes_rsp_if.sv
rtl/hes_ram.sv
rtl/hashed_entry_store_oldest_evict_core.sv
rtl/hes_checker.sv
sim/hes_tb_if.sv
sim/testbench.sv
